// ===== hdl/mlq_pkg.sv =====
// Shared package for the multilevel queue with delete.
// Holds request and status codes, default sizes and the command and status
// bundles that pass between the controller and the datapath.
package mlq_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int DEF_QUEUE_DEPTH = 64;
	localparam int DEF_NUM_LEVELS  = 4;

	// Fixed field widths of the request and result ports.
	localparam int REQ_W   = 3;
	localparam int LEVEL_W = 2;
	localparam int ID_W    = 15;
	localparam int POS_W   = 6;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              capture;    // register the accepted request
		logic              clear_all;  // zero every level count
		logic              wr_append;  // write the identifier at the tail
		logic              cnt_inc;    // grow the addressed level
		logic              cnt_dec;    // shrink the addressed level
		logic              ptr_clr;    // read pointer to the head
		logic              ptr_pos;    // read pointer to the requested position
		logic              ptr_gap;    // read pointer just past the last read entry
		logic              rd_en;      // read the entry under the pointer
		logic              wr_shift;   // write the last read entry one slot lower
		logic              id_capture; // keep the last read entry as the result id
		logic              res_load;   // load the result register
		logic [STAT_W-1:0] res_status; // status code for the result
	} mlq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic             lvl_ok;   // addressed level exists
		logic             empty;    // addressed level holds nothing
		logic             full;     // addressed level is at capacity
		logic             ptr_lt_n; // read pointer is below the level count
		logic             pos_lt_n; // requested position is below the level count
		logic             rd_vld;   // read data is valid this cycle
		logic             match;    // read data equals the requested identifier
		logic             last_rd;  // read data came from the tail slot
	} mlq_stat_t;

endpackage

// ===== hdl/mlq_dpath.sv =====
// Datapath of the multilevel queue: request registers, level counts, the
// entry memory with its read pointer, and the result register.
// Depends on mlq_pkg.
module mlq_dpath #(
	parameter int QUEUE_DEPTH = mlq_pkg::DEF_QUEUE_DEPTH,
	parameter int NUM_LEVELS  = mlq_pkg::DEF_NUM_LEVELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mlq_pkg::REQ_W-1:0]     req_type,
	input  logic [mlq_pkg::LEVEL_W-1:0]   level,
	input  logic [mlq_pkg::ID_W-1:0]      proc_id,
	input  logic [mlq_pkg::POS_W-1:0]     position,
	input  mlq_pkg::mlq_cmd_t             cmd,
	output mlq_pkg::mlq_stat_t            stat,
	output logic [mlq_pkg::ID_W-1:0]      id_out,
	output logic [mlq_pkg::STAT_W-1:0]    status,
	output logic [mlq_pkg::COUNT_W-1:0]   count,
	output logic                          is_empty,
	output logic                          is_full
);
	import mlq_pkg::*;

	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int IW    = $clog2(QUEUE_DEPTH);
	localparam int LW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int AW    = LW + IW;
	localparam int MDEPTH = NUM_LEVELS << IW;

	// Registered request fields.
	logic [REQ_W-1:0]   req_q;
	logic [LEVEL_W-1:0] level_q;
	logic [ID_W-1:0]    pid_q;
	logic [POS_W-1:0]   pos_q;

	logic [CW-1:0] cnt_q [NUM_LEVELS];
	logic [CW-1:0] ptr_q;
	logic [IW-1:0] rd_idx_s1;
	logic          rd_vld_s1;
	logic [ID_W-1:0] rd_data_s1;
	logic [ID_W-1:0] id_q;
	logic [ID_W-1:0] mem [MDEPTH];

	logic          lvl_ok;
	logic [LW-1:0] lvl_idx;
	logic [CW-1:0] n;
	logic [CW-1:0] rd_next;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [ID_W-1:0] wr_data;

	// Addressed level and its count.
	assign lvl_ok  = ({30'd0, level_q} < 32'(NUM_LEVELS));
	assign lvl_idx = LW'(level_q);
	assign n       = lvl_ok ? cnt_q[lvl_idx] : '0;
	assign rd_next = CW'(rd_idx_s1) + CW'(1);

	// Status toward the controller.
	always_comb begin
		stat.req_type = req_q;
		stat.lvl_ok   = lvl_ok;
		stat.empty    = (n == '0);
		stat.full     = (n >= CW'(QUEUE_DEPTH));
		stat.ptr_lt_n = (ptr_q < n);
		stat.pos_lt_n = ({{CW{1'b0}}, pos_q} < {{POS_W{1'b0}}, n});
		stat.rd_vld   = rd_vld_s1;
		stat.match    = (rd_data_s1 == pid_q);
		stat.last_rd  = (rd_next == n);
	end

	// Request registers, loaded when a request is accepted.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= req_type;
			level_q <= level;
			pid_q   <= proc_id;
			pos_q   <= position;
		end
	end

	// Level counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) cnt_q[i] <= '0;
		end else if (cmd.clear_all) begin
			for (int i = 0; i < NUM_LEVELS; i++) cnt_q[i] <= '0;
		end else if (cmd.cnt_inc && lvl_ok) begin
			cnt_q[lvl_idx] <= n + CW'(1);
		end else if (cmd.cnt_dec && lvl_ok) begin
			cnt_q[lvl_idx] <= n - CW'(1);
		end
	end

	// Read pointer and the valid flag of the read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_pos) begin
				ptr_q <= CW'(pos_q);
			end else if (cmd.ptr_gap) begin
				ptr_q <= rd_next;
			end else if (cmd.rd_en) begin
				ptr_q <= ptr_q + CW'(1);
			end
		end
	end

	// Write port: a tail append or one step of closing a gap.
	always_comb begin
		wr_en   = cmd.wr_append | (cmd.wr_shift & rd_vld_s1);
		wr_addr = {lvl_idx, n[IW-1:0]};
		wr_data = pid_q;
		if (cmd.wr_shift) begin
			wr_addr = {lvl_idx, rd_idx_s1 - IW'(1)};
			wr_data = rd_data_s1;
		end
	end

	// Entry memory with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[{lvl_idx, ptr_q[IW-1:0]}];
			rd_idx_s1  <= ptr_q[IW-1:0];
		end
	end

	// Result identifier, zero unless an entry was fetched.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q <= '0;
		end else if (cmd.id_capture) begin
			id_q <= rd_data_s1;
		end
	end

	// Result register, held while the result waits.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			id_out   <= id_q;
			status   <= cmd.res_status;
			count    <= COUNT_W'(n);
			is_empty <= (n == '0);
			is_full  <= (n == CW'(QUEUE_DEPTH));
		end
	end

endmodule

// ===== hdl/mlq_ctrl.sv =====
// Controller of the multilevel queue: request handshake, sequencing of the
// scan, fetch and gap-closing steps, and the result handshake.
// Depends on mlq_pkg.
module mlq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  mlq_pkg::mlq_stat_t  stat,
	output mlq_pkg::mlq_cmd_t   cmd
);
	import mlq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_FETCH,
		S_RD_WAIT,
		S_SCAN,
		S_SHIFT,
		S_RESULT
	} state_t;

	state_t            state_q, state_d;
	logic [STAT_W-1:0] st_q, st_d;
	logic              out_valid_q;
	logic              out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		cmd     = '0;
		cmd.res_status = st_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				st_d    = ST_OK;
				state_d = S_RESULT;
				case (stat.req_type)
					REQ_CLEAR: begin
						cmd.clear_all = 1'b1;
					end
					REQ_APPEND, REQ_REMOVE, REQ_POP, REQ_PEEK, REQ_READ: begin
						if (!stat.lvl_ok) begin
							st_d = ST_EMPTY;
						end else if (stat.req_type == REQ_APPEND) begin
							if (stat.full) begin
								st_d = ST_FULL;
							end else begin
								cmd.wr_append = 1'b1;
								cmd.cnt_inc   = 1'b1;
							end
						end else if (stat.req_type == REQ_READ) begin
							if (stat.pos_lt_n) begin
								cmd.ptr_pos = 1'b1;
								state_d     = S_FETCH;
							end else begin
								st_d = stat.empty ? ST_EMPTY : ST_NOTFOUND;
							end
						end else if (stat.empty) begin
							st_d = ST_EMPTY;
						end else begin
							cmd.ptr_clr = 1'b1;
							state_d = (stat.req_type == REQ_REMOVE) ? S_SCAN : S_FETCH;
						end
					end
					default: begin
						st_d = ST_OK;
					end
				endcase
			end
			S_FETCH: begin
				cmd.rd_en = 1'b1;
				state_d   = S_RD_WAIT;
			end
			S_RD_WAIT: begin
				cmd.id_capture = 1'b1;
				if (stat.req_type == REQ_POP) begin
					cmd.ptr_gap = 1'b1;
					state_d     = S_SHIFT;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_SCAN: begin
				// Compare each returned entry while the next read is in flight.
				if (stat.rd_vld && stat.match) begin
					cmd.ptr_gap = 1'b1;
					state_d     = S_SHIFT;
				end else if (stat.rd_vld && stat.last_rd) begin
					st_d    = ST_NOTFOUND;
					state_d = S_RESULT;
				end else begin
					cmd.rd_en = stat.ptr_lt_n;
				end
			end
			S_SHIFT: begin
				// Each entry above the gap is read and written one slot lower.
				cmd.rd_en    = stat.ptr_lt_n;
				cmd.wr_shift = stat.rd_vld;
				if (!stat.rd_vld && !stat.ptr_lt_n) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_RESULT;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, status code and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/multilevel_queue_with_delete.sv =====
// Multilevel queue with delete: one request at a time, one result per request.
// Append, clear and rejected requests pass from decode straight to the result;
// peek and read position fetch one entry first; pop fetches the head and then
// closes the gap, and remove scans the level and closes the gap it finds,
// entry by entry. A new request is taken once the previous result is queued.
// Reset clears every level count and the handshakes; entries need no clearing.
module multilevel_queue_with_delete #(
	parameter int QUEUE_DEPTH = mlq_pkg::DEF_QUEUE_DEPTH,
	parameter int NUM_LEVELS  = mlq_pkg::DEF_NUM_LEVELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mlq_pkg::REQ_W-1:0]     req_type,
	input  logic [mlq_pkg::LEVEL_W-1:0]   level,
	input  logic [mlq_pkg::ID_W-1:0]      proc_id,
	input  logic [mlq_pkg::POS_W-1:0]     position,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mlq_pkg::ID_W-1:0]      id_out,
	output logic [mlq_pkg::STAT_W-1:0]    status,
	output logic [mlq_pkg::COUNT_W-1:0]   count,
	output logic                          is_empty,
	output logic                          is_full
);
	import mlq_pkg::*;

	mlq_cmd_t  cmd;
	mlq_stat_t stat;

	// Sequencer.
	mlq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage and result datapath.
	mlq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.NUM_LEVELS  (NUM_LEVELS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_type (req_type),
		.level    (level),
		.proc_id  (proc_id),
		.position (position),
		.cmd      (cmd),
		.stat     (stat),
		.id_out   (id_out),
		.status   (status),
		.count    (count),
		.is_empty (is_empty),
		.is_full  (is_full)
	);

`ifndef SYNTH
	// Only one request is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while another is in work");

	// A dropped append always reports a full level.
	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> is_full && !is_empty)
		else $error("full status without full flag");

	// A fresh result always follows a request in work.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no request in work");
`endif

endmodule

// ===== tb/multilevel_queue_with_delete_tb.sv =====
// Self-checking bench for the multilevel queue with delete by value.
// Sends directed and random queue requests, keeps its own model of every level
// and checks each reply field by field; depends on mlq_pkg and the top module.
module multilevel_queue_with_delete_tb;
	import mlq_pkg::*;

	localparam int DEPTH = DEF_QUEUE_DEPTH;
	localparam int LEVELS = DEF_NUM_LEVELS;
	localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;
	localparam logic [ID_W-1:0] ID_MAX = '1;
	localparam int POS_MAX = 2 ** POS_W - 1;
	localparam int REQUEST_TARGET = 1250;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
	localparam int CYCLE_LIMIT = 1500000;
	localparam logic [REQ_W-1:0] PROBE_KINDS [4] = '{REQ_POP, REQ_REMOVE, REQ_PEEK, REQ_READ};

	typedef struct {
		logic [REQ_W-1:0]   kind;
		logic [LEVEL_W-1:0] lvl;
		logic [ID_W-1:0]    pid;
		logic [POS_W-1:0]   pos;
		bit                 drain_first;
	} queue_request_t;

	typedef struct {
		logic [ID_W-1:0]    id;
		logic [STAT_W-1:0]  st;
		logic [COUNT_W-1:0] cnt;
		logic               empty;
		logic               full;
	} queue_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [REQ_W-1:0] req_type = '0;
	logic [LEVEL_W-1:0] level = '0;
	logic [ID_W-1:0] proc_id = '0;
	logic [POS_W-1:0] position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ID_W-1:0] id_out;
	logic [STAT_W-1:0] status;
	logic [COUNT_W-1:0] count;
	logic is_empty;
	logic is_full;

	// Model of the block: entries and counts per level.
	logic [ID_W-1:0] lvl_entry [LEVELS][DEPTH];
	logic [COUNT_W-1:0] lvl_count [LEVELS] = '{default: '0};

	// Identifiers per level as the generator expects them, used to aim removes.
	logic [ID_W-1:0] level_ids [LEVELS][$];
	bit pause_next = 1'b0;

	queue_request_t requests_to_send[$];
	queue_reply_t replies_due[$];
	queue_request_t on_bus;
	queue_reply_t want;
	logic offering;
	int gap_left = 0;
	int calm_in = 0;
	int stall_left = 0;
	int calm_out = 0;
	int hold_left = 0;
	int holds_done = 0;
	int next_hold_at = 150;
	int requests_taken = 0;
	int replies_seen = 0;
	int errors = 0;
	int cycle_count = 0;

	multilevel_queue_with_delete DUT (.*);

	always #4 clk = ~clk;

	// Mostly no gap, sometimes a short one and rarely a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99, 0);
		if (roll < 70) return 0;
		if (roll < 95) return $urandom_range(4, 1);
		return $urandom_range(60, 10);
	endfunction

	// Drop slot idx of a level and move the later entries down by one.
	function automatic void close_gap(input int lv, input int idx);
		int n;
		int k;
		n = lvl_count[lv];
		for (k = idx; k + 1 < n; k++) begin
			lvl_entry[lv][k] = lvl_entry[lv][k + 1];
		end
		lvl_count[lv] = COUNT_W'(n - 1);
	endfunction

	// Apply one request to the model and return the reply it must produce.
	function automatic queue_reply_t serve_request(input queue_request_t r);
		queue_reply_t res;
		int lv;
		int n;
		int hit;
		int k;
		lv = r.lvl;
		res.id = '0;
		res.st = ST_OK;
		if (r.kind == REQ_CLEAR) begin
			for (k = 0; k < LEVELS; k++) begin
				lvl_count[k] = '0;
			end
		end else if (r.kind <= REQ_CLEAR) begin
			// Codes above clear are no-ops and fall through to the flags.
			n = lvl_count[lv];
			case (r.kind)
				REQ_APPEND: begin
					if (n >= DEPTH) begin
						res.st = ST_FULL;
					end else begin
						lvl_entry[lv][n] = r.pid;
						lvl_count[lv] = COUNT_W'(n + 1);
					end
				end
				REQ_REMOVE: begin
					if (n == 0) begin
						res.st = ST_EMPTY;
					end else begin
						hit = -1;
						for (k = 0; k < n; k++) begin
							if (hit < 0 && lvl_entry[lv][k] == r.pid) hit = k;
						end
						if (hit < 0) res.st = ST_NOTFOUND;
						else close_gap(lv, hit);
					end
				end
				REQ_POP: begin
					if (n == 0) begin
						res.st = ST_EMPTY;
					end else begin
						res.id = lvl_entry[lv][0];
						close_gap(lv, 0);
					end
				end
				REQ_PEEK: begin
					if (n == 0) res.st = ST_EMPTY;
					else res.id = lvl_entry[lv][0];
				end
				default: begin
					if (r.pos < n) res.id = lvl_entry[lv][r.pos];
					else res.st = (n == 0) ? ST_EMPTY : ST_NOTFOUND;
				end
			endcase
		end
		res.cnt = lvl_count[lv];
		res.empty = (res.cnt == 0);
		res.full = (res.cnt == DEPTH);
		return res;
	endfunction

	function automatic logic [ID_W-1:0] random_id();
		return ID_W'($urandom_range(2 ** ID_W - 1, 0));
	endfunction

	// An identifier that currently sits in the level; the level must not be empty.
	function automatic logic [ID_W-1:0] pick_resident(input int lv);
		return level_ids[lv][$urandom_range(level_ids[lv].size() - 1, 0)];
	endfunction

	// Queue one request for the driver and track what the level will hold.
	function automatic void queue_up(input logic [REQ_W-1:0] kind, input int lv,
			input logic [ID_W-1:0] pid, input int pos);
		queue_request_t r;
		int idx;
		int k;
		r.kind = kind;
		r.lvl = LEVEL_W'(lv);
		r.pid = pid;
		r.pos = POS_W'(pos);
		r.drain_first = pause_next;
		pause_next = 1'b0;
		requests_to_send.push_back(r);
		case (kind)
			REQ_APPEND: begin
				if (level_ids[lv].size() < DEPTH) level_ids[lv].push_back(pid);
			end
			REQ_REMOVE: begin
				idx = -1;
				for (k = 0; k < level_ids[lv].size(); k++) begin
					if (idx < 0 && level_ids[lv][k] == pid) idx = k;
				end
				if (idx >= 0) level_ids[lv].delete(idx);
			end
			REQ_POP: begin
				if (level_ids[lv].size() > 0) void'(level_ids[lv].pop_front());
			end
			REQ_CLEAR: begin
				for (k = 0; k < LEVELS; k++) begin
					level_ids[k].delete();
				end
			end
			default: begin
			end
		endcase
	endfunction

	task automatic build_stimulus();
		int lv;
		int roll;
		int n;
		// Directed: empty levels, field extremes, every request kind and edge case.
		queue_up(REQ_CLEAR, 3, ID_MAX, POS_MAX);
		queue_up(REQ_POP, 0, '0, 0);
		queue_up(REQ_PEEK, 1, ID_MAX, 0);
		queue_up(REQ_READ, 2, '0, POS_MAX);
		queue_up(REQ_REMOVE, 3, ID_MAX, 0);
		queue_up(REQ_APPEND, 0, ID_MAX, 0);
		queue_up(REQ_APPEND, 0, '0, POS_MAX);
		queue_up(REQ_APPEND, 0, 15'h5555, 0);
		queue_up(REQ_APPEND, 3, 15'h2aaa, 0);
		queue_up(REQ_READ, 0, '0, 0);
		queue_up(REQ_READ, 0, '0, 2);
		queue_up(REQ_READ, 0, '0, 3);
		queue_up(REQ_READ, 0, '0, POS_MAX);
		queue_up(REQ_PEEK, 0, '0, 0);
		queue_up(REQ_REMOVE, 0, 15'h1234, 0);
		queue_up(REQ_REMOVE, 0, '0, 0);
		queue_up(REQ_READ, 0, '0, 1);
		queue_up(REQ_POP, 0, '0, 0);
		queue_up(REQ_SPARE_A, 0, random_id(), $urandom_range(POS_MAX, 0));
		queue_up(REQ_SPARE_B, 3, ID_MAX, POS_MAX);
		queue_up(REQ_REMOVE, 3, 15'h2aaa, 0);
		queue_up(REQ_APPEND, 2, 15'h4000, 0);
		queue_up(REQ_CLEAR, 1, '0, 0);
		queue_up(REQ_PEEK, 2, '0, 0);
		queue_up(REQ_READ, 0, '0, 0);

		// Random bursts; the first waits until the directed replies are in.
		pause_next = 1'b1;
		while (requests_to_send.size() < REQUEST_TARGET) begin
			if ($urandom_range(11, 0) == 0) pause_next = 1'b1;
			lv = $urandom_range(LEVELS - 1, 0);
			roll = $urandom_range(99, 0);
			if (roll < 30) begin
				// Fill one level to the top, then push past full.
				while (level_ids[lv].size() < DEPTH) begin
					roll = $urandom_range(9, 0);
					n = level_ids[lv].size();
					if (roll == 0)
						queue_up(REQ_PEEK, lv, random_id(), $urandom_range(POS_MAX, 0));
					else if (roll == 1 && n > 0)
						queue_up(REQ_READ, lv, random_id(), $urandom_range(n - 1, 0));
					else if (roll < 4 && n > 0)
						queue_up(REQ_APPEND, lv, pick_resident(lv), $urandom_range(POS_MAX, 0));
					else
						queue_up(REQ_APPEND, lv, random_id(), $urandom_range(POS_MAX, 0));
				end
				repeat ($urandom_range(3, 1))
					queue_up(REQ_APPEND, lv, random_id(), $urandom_range(POS_MAX, 0));
			end else if (roll < 58) begin
				// Drain one level by pops and removes from anywhere, then probe it empty.
				while (level_ids[lv].size() > 0) begin
					roll = $urandom_range(9, 0);
					if (roll < 4)
						queue_up(REQ_POP, lv, random_id(), $urandom_range(POS_MAX, 0));
					else if (roll < 8)
						queue_up(REQ_REMOVE, lv, pick_resident(lv), $urandom_range(POS_MAX, 0));
					else if (roll == 8)
						queue_up(REQ_REMOVE, lv, random_id(), $urandom_range(POS_MAX, 0));
					else
						queue_up(REQ_READ, lv, random_id(), $urandom_range(POS_MAX, 0));
				end
				queue_up(PROBE_KINDS[$urandom_range(3, 0)], lv, random_id(),
					$urandom_range(POS_MAX, 0));
			end else if (roll < 93) begin
				// Mixed traffic across all levels.
				repeat ($urandom_range(40, 20)) begin
					lv = $urandom_range(LEVELS - 1, 0);
					n = level_ids[lv].size();
					roll = $urandom_range(99, 0);
					if (roll < 30) begin
						if (n > 0 && $urandom_range(3, 0) == 0)
							queue_up(REQ_APPEND, lv, pick_resident(lv), 0);
						else
							queue_up(REQ_APPEND, lv, random_id(), $urandom_range(POS_MAX, 0));
					end else if (roll < 50) begin
						if (n > 0 && $urandom_range(9, 0) < 7)
							queue_up(REQ_REMOVE, lv, pick_resident(lv), 0);
						else
							queue_up(REQ_REMOVE, lv, random_id(), $urandom_range(POS_MAX, 0));
					end else if (roll < 65) begin
						queue_up(REQ_POP, lv, random_id(), $urandom_range(POS_MAX, 0));
					end else if (roll < 75) begin
						queue_up(REQ_PEEK, lv, random_id(), $urandom_range(POS_MAX, 0));
					end else if (roll < 95) begin
						if (n > 0 && $urandom_range(4, 0) != 0)
							queue_up(REQ_READ, lv, random_id(), $urandom_range(n - 1, 0));
						else
							queue_up(REQ_READ, lv, random_id(), $urandom_range(POS_MAX, 0));
					end else if (roll < 97) begin
						queue_up(REQ_CLEAR, lv, random_id(), $urandom_range(POS_MAX, 0));
					end else begin
						queue_up($urandom_range(1, 0) ? REQ_SPARE_A : REQ_SPARE_B, lv,
							random_id(), $urandom_range(POS_MAX, 0));
					end
				end
			end else begin
				// Noise: any code, any level, any fields.
				repeat ($urandom_range(10, 4)) begin
					queue_up(REQ_W'($urandom_range(2 ** REQ_W - 1, 0)),
						$urandom_range(LEVELS - 1, 0), random_id(),
						$urandom_range(POS_MAX, 0));
				end
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_v);
		if (got !== exp_v) begin
			report_mismatch($sformatf("reply %0d %s is %0h, expected %0h", replies_seen, name,
				got, exp_v));
		end
	endtask

	// Request driver: the model is updated when a request is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offering = in_valid;
			if (in_valid && !in_stall) begin
				replies_due.push_back(serve_request(on_bus));
				requests_taken++;
				offering = 1'b0;
				if (calm_in > 0) begin
					calm_in--;
					gap_left = 0;
				end else begin
					gap_left = pick_gap();
					if ($urandom_range(59, 0) == 0) calm_in = $urandom_range(120, 40);
				end
			end
			if (!offering) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (requests_to_send.size() > 0 &&
						(!requests_to_send[0].drain_first || replies_due.size() == 0)) begin
					on_bus = requests_to_send.pop_front();
					offering = 1'b1;
					req_type <= on_bus.kind;
					level <= on_bus.lvl;
					proc_id <= on_bus.pid;
					position <= on_bus.pos;
				end
			end
			in_valid <= offering;
		end
	end

	// Reply stall: random gaps, calm stretches, and two long hold-offs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_left == 0 && holds_done < 2 && requests_taken >= next_hold_at) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
				next_hold_at += 550;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (calm_out > 0) begin
					calm_out--;
				end else begin
					stall_left = pick_gap();
					if ($urandom_range(59, 0) == 0) calm_out = $urandom_range(120, 40);
				end
			end
		end
	end

	// Reply checker against the oldest outstanding expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				report_mismatch($sformatf("reply with no request outstanding: id %0h status %0d",
					id_out, status));
			end else begin
				want = replies_due.pop_front();
				check_field("id_out", 32'(id_out), 32'(want.id));
				check_field("status", 32'(status), 32'(want.st));
				check_field("count", 32'(count), 32'(want.cnt));
				check_field("is_empty", 32'(is_empty), 32'(want.empty));
				check_field("is_full", 32'(is_full), 32'(want.full));
			end
			replies_seen++;
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		build_stimulus();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// Sample between edges so the driver's updates of this cycle are settled.
		while (requests_to_send.size() > 0 || in_valid || replies_due.size() > 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== multilevel_queue_with_delete.f =====
hdl/mlq_pkg.sv
hdl/mlq_dpath.sv
hdl/mlq_ctrl.sv
hdl/multilevel_queue_with_delete.sv
tb/multilevel_queue_with_delete_tb.sv
